### design/irpwd_pkg.sv
`timescale 1ns / 1ps

package irpwd_pkg;

    // Register indexes on the configuration channel.
    localparam logic [2:0] REG_MARGIN    = 3'd0;
    localparam logic [2:0] REG_SYNC      = 3'd1;
    localparam logic [2:0] REG_PAUSE     = 3'd2;
    localparam logic [2:0] REG_BIT_MIN   = 3'd3;
    localparam logic [2:0] REG_BIT_SPLIT = 3'd4;
    localparam logic [2:0] REG_BIT_MAX   = 3'd5;
    localparam logic [2:0] REG_ACTIVE    = 3'd6;

    // Reset values of the timing registers, in samples.
    localparam int RST_MARGIN    = 199;
    localparam int RST_SYNC      = 3299;
    localparam int RST_PAUSE     = 1499;
    localparam int RST_BIT_MIN   = 199;
    localparam int RST_BIT_SPLIT = 589;
    localparam int RST_BIT_MAX   = 1199;

    // At most this many packet words are sent for one packet end.
    localparam int MAX_OUT_WORDS = 4;

    typedef enum logic [1:0] {
        KIND_SYNC  = 2'd0,
        KIND_PAUSE = 2'd1,
        KIND_BIT   = 2'd2,
        KIND_WORD  = 2'd3
    } kind_t;

    // Interval classification handed from the classifier to the sequencer.
    typedef struct packed {
        logic sync_ok;
        logic pause_ok;
        logic bit_ok;
        logic bit_val;
    } class_t;

    // One result transaction.
    typedef struct packed {
        kind_t       kind;
        logic        bit_value;
        logic [8:0]  bit_total;
        logic [1:0]  word_index;
        logic [63:0] packet_word;
        logic        last;
    } res_t;

    // Sequencer status seen by the top level.
    typedef struct packed {
        logic take;
        logic emitting;
    } seq_stat_t;

endpackage

### design/irpwd_window.sv
`timescale 1ns / 1ps

module irpwd_window #(
    parameter int TIME_WIDTH = 24
) (
    input  logic [TIME_WIDTH-1:0] len,
    input  logic [TIME_WIDTH-1:0] centre,
    input  logic [TIME_WIDTH-1:0] tol,
    output logic                  hit
);

    // The upper bound keeps its carry bit; it saturates only for widths of 64 bits or more.
    localparam bit SAT_HI = (TIME_WIDTH >= 64);

    logic [TIME_WIDTH:0]   sum;
    logic [TIME_WIDTH:0]   hi;
    logic [TIME_WIDTH-1:0] lo;

    always_comb begin
        sum = {1'b0, centre} + {1'b0, tol};
        hi  = (SAT_HI && sum[TIME_WIDTH]) ? {1'b0, {TIME_WIDTH{1'b1}}} : sum;
        lo  = (tol > centre) ? '0 : centre - tol;
        hit = (len >= lo) && ({1'b0, len} < hi);
    end

endmodule

### design/irpwd_classify.sv
`timescale 1ns / 1ps

module irpwd_classify #(
    parameter int TIME_WIDTH = 24
) (
    input  logic [TIME_WIDTH-1:0] len,
    input  logic [TIME_WIDTH-1:0] margin_len,
    input  logic [TIME_WIDTH-1:0] sync_len,
    input  logic [TIME_WIDTH-1:0] pause_len,
    input  logic [TIME_WIDTH-1:0] bit_min_len,
    input  logic [TIME_WIDTH-1:0] bit_split_len,
    input  logic [TIME_WIDTH-1:0] bit_max_len,
    output irpwd_pkg::class_t     cls
);

    import irpwd_pkg::*;

    logic sync_hit;
    logic pause_hit;
    logic zero_hit;
    logic one_hit;

    irpwd_window #(.TIME_WIDTH(TIME_WIDTH)) u_sync_win (
        .len    (len),
        .centre (sync_len),
        .tol    (margin_len),
        .hit    (sync_hit)
    );

    irpwd_window #(.TIME_WIDTH(TIME_WIDTH)) u_pause_win (
        .len    (len),
        .centre (pause_len),
        .tol    (margin_len),
        .hit    (pause_hit)
    );

    always_comb begin
        zero_hit     = (len >= bit_min_len) && (len < bit_split_len);
        one_hit      = (len >= bit_split_len) && (len < bit_max_len);
        cls.sync_ok  = sync_hit;
        cls.pause_ok = pause_hit;
        cls.bit_ok   = zero_hit || one_hit;
        // A zero takes precedence; the two ranges cannot overlap anyway.
        cls.bit_val  = !zero_hit;
    end

endmodule

### design/irpwd_cfg_regs.sv
`timescale 1ns / 1ps

module irpwd_cfg_regs #(
    parameter int TIME_WIDTH = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [2:0]            wr_index,
    input  logic [TIME_WIDTH-1:0] wr_data,
    output logic [TIME_WIDTH-1:0] margin_len,
    output logic [TIME_WIDTH-1:0] sync_len,
    output logic [TIME_WIDTH-1:0] pause_len,
    output logic [TIME_WIDTH-1:0] bit_min_len,
    output logic [TIME_WIDTH-1:0] bit_split_len,
    output logic [TIME_WIDTH-1:0] bit_max_len,
    output logic                  active_level
);

    import irpwd_pkg::*;

    logic [TIME_WIDTH-1:0] margin_reg;
    logic [TIME_WIDTH-1:0] sync_reg;
    logic [TIME_WIDTH-1:0] pause_reg;
    logic [TIME_WIDTH-1:0] bit_min_reg;
    logic [TIME_WIDTH-1:0] bit_split_reg;
    logic [TIME_WIDTH-1:0] bit_max_reg;
    logic                  active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg    <= TIME_WIDTH'(RST_MARGIN);
            sync_reg      <= TIME_WIDTH'(RST_SYNC);
            pause_reg     <= TIME_WIDTH'(RST_PAUSE);
            bit_min_reg   <= TIME_WIDTH'(RST_BIT_MIN);
            bit_split_reg <= TIME_WIDTH'(RST_BIT_SPLIT);
            bit_max_reg   <= TIME_WIDTH'(RST_BIT_MAX);
            active_reg    <= 1'b0;
        end else if (wr_en) begin
            case (wr_index)
                REG_MARGIN:    margin_reg    <= wr_data;
                REG_SYNC:      sync_reg      <= wr_data;
                REG_PAUSE:     pause_reg     <= wr_data;
                REG_BIT_MIN:   bit_min_reg   <= wr_data;
                REG_BIT_SPLIT: bit_split_reg <= wr_data;
                REG_BIT_MAX:   bit_max_reg   <= wr_data;
                REG_ACTIVE:    active_reg    <= wr_data[0];
                default: ;
            endcase
        end
    end

    assign margin_len    = margin_reg;
    assign sync_len      = sync_reg;
    assign pause_len     = pause_reg;
    assign bit_min_len   = bit_min_reg;
    assign bit_split_len = bit_split_reg;
    assign bit_max_len   = bit_max_reg;
    assign active_level  = active_reg;

endmodule

### design/irpwd_seq.sv
`timescale 1ns / 1ps

module irpwd_seq #(
    parameter int MAX_BITS = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 in_level,
    input  logic                 in_tmo,
    input  irpwd_pkg::class_t    cls,
    input  logic                 active_level,
    input  logic                 out_free,
    output logic                 res_valid,
    output irpwd_pkg::res_t      res,
    output irpwd_pkg::seq_stat_t stat
);

    import irpwd_pkg::*;

    localparam int STORE_WORDS = (MAX_BITS + 63) / 64;
    localparam int SW_IDX_W    = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int CNT_W       = $clog2(MAX_BITS + 1);
    localparam int OUT_WORDS   = (STORE_WORDS < MAX_OUT_WORDS) ? STORE_WORDS : MAX_OUT_WORDS;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_SYNCING = 2'd1,
        MODE_DATA    = 2'd2
    } mode_t;

    mode_t             mode_reg;
    mode_t             mode_next;
    logic [CNT_W-1:0]  bit_count_reg;
    logic [CNT_W-1:0]  bit_count_next;
    logic [63:0]       store_reg [STORE_WORDS];
    logic              emit_active_reg;
    logic [1:0]        emit_idx_reg;
    logic [1:0]        emit_last_reg;

    logic              take;
    logic              emit_fire;
    logic              store_we;
    logic              end_pkt;
    logic [CNT_W+5:0]  cnt_ext;
    logic [5:0]        wr_pos;
    logic [SW_IDX_W-1:0] wr_word;
    logic [SW_IDX_W-1:0] rd_word;
    logic [CNT_W+5:0]  words_ceil;
    logic [CNT_W+5:0]  words_cap;

    always_comb begin
        cnt_ext    = (CNT_W + 6)'(bit_count_reg);
        wr_pos     = cnt_ext[5:0];
        wr_word    = SW_IDX_W'(cnt_ext >> 6);
        rd_word    = SW_IDX_W'(emit_idx_reg);
        words_ceil = (cnt_ext + (CNT_W + 6)'(63)) >> 6;
        words_cap  = (words_ceil > (CNT_W + 6)'(OUT_WORDS)) ? (CNT_W + 6)'(OUT_WORDS)
                                                             : words_ceil;
    end

    always_comb begin
        take           = in_valid && !emit_active_reg && out_free;
        emit_fire      = emit_active_reg && out_free;
        mode_next      = mode_reg;
        bit_count_next = bit_count_reg;
        store_we       = 1'b0;
        end_pkt        = 1'b0;
        res_valid      = 1'b0;
        res            = '0;
        res.last       = 1'b1;

        if (emit_fire) begin
            res_valid       = 1'b1;
            res.kind        = KIND_WORD;
            res.bit_total   = 9'(bit_count_reg);
            res.word_index  = emit_idx_reg;
            res.packet_word = store_reg[rd_word];
            res.last        = (emit_idx_reg == emit_last_reg);
        end else if (take) begin
            case (mode_reg)
                MODE_SYNCING: begin
                    if (cls.pause_ok) begin
                        mode_next = MODE_DATA;
                        res_valid = 1'b1;
                        res.kind  = KIND_PAUSE;
                        res.bit_total = 9'(bit_count_reg);
                    end else begin
                        mode_next = MODE_IDLE;
                        end_pkt   = 1'b1;
                    end
                end
                MODE_DATA: begin
                    if (in_tmo || !cls.bit_ok) begin
                        mode_next = MODE_IDLE;
                        end_pkt   = 1'b1;
                    end else begin
                        if (bit_count_reg < CNT_W'(MAX_BITS)) begin
                            store_we       = 1'b1;
                            bit_count_next = bit_count_reg + 1'b1;
                        end
                        res_valid     = 1'b1;
                        res.kind      = KIND_BIT;
                        res.bit_value = cls.bit_val;
                        res.bit_total = 9'(bit_count_next);
                    end
                end
                default: begin
                    // Idle, and the unused mode code, look for a sync pulse.
                    mode_next = MODE_IDLE;
                    if ((in_level == active_level) && cls.sync_ok) begin
                        mode_next      = MODE_SYNCING;
                        bit_count_next = '0;
                        res_valid      = 1'b1;
                        res.kind       = KIND_SYNC;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            bit_count_reg   <= '0;
            emit_active_reg <= 1'b0;
            emit_idx_reg    <= '0;
            emit_last_reg   <= '0;
        end else begin
            mode_reg      <= mode_next;
            bit_count_reg <= bit_count_next;
            if (store_we) begin
                // The first bit of a word clears the rest of it, so no masking
                // is needed when the word is sent.
                if (wr_pos == 6'd0) begin
                    store_reg[wr_word] <= 64'(cls.bit_val);
                end else begin
                    store_reg[wr_word][wr_pos] <= cls.bit_val;
                end
            end
            if (take && end_pkt && (words_ceil != '0)) begin
                emit_active_reg <= 1'b1;
                emit_idx_reg    <= '0;
                emit_last_reg   <= 2'(words_cap - 1'b1);
            end else if (emit_fire) begin
                if (res.last) begin
                    emit_active_reg <= 1'b0;
                end else begin
                    emit_idx_reg <= emit_idx_reg + 1'b1;
                end
            end
        end
    end

    assign stat.take     = take;
    assign stat.emitting = emit_active_reg;

endmodule

### design/ir_pulse_width_frame_decoder.sv
`timescale 1ns / 1ps

// Infrared pulse-width frame decoder.
//
// Each slave transaction carries one line interval: its length in samples and
// the line level held during it (s_tdata), and a flag that the interval ended
// by a data timeout rather than an edge (s_tuser). The decoder finds a sync
// pulse, then a sync pause, then decodes data intervals into bits by length.
// Every sync, pause and data bit gives one master transaction, with the kind
// on m_tuser. When a packet ends, the collected bits follow as up to four
// 64-bit packet words, bit 0 first, the final one marked by m_tlast.
//
// The input sits in a register; classification and the state update are
// combinational from there into the result register, and a new transaction is
// accepted every cycle while the master side takes results and no packet words
// are being sent. After a packet end the next input waits while the words are
// read from the bit store, one per cycle while the master side takes them.
// When the master side stalls, the result register and the input register
// together hold two items before s_tready falls.
// Reset (aresetn low, synchronous) returns to idle, empties both registers,
// clears the bit count and reloads the timing registers; the configuration
// channel is always ready and should be written only while the block is idle.
module ir_pulse_width_frame_decoder #(
    parameter int MAX_BITS   = 256,
    parameter int TIME_WIDTH = 24,
    localparam int S_TDATA_W = ((TIME_WIDTH + 1 + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // interval_len, line_level, zero fill
    input  logic                  s_tuser,   // timed_out

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [79:0]           m_tdata,   // bit_value, bit_total, word_index,
                                             // packet_word, zero fill
    output logic [1:0]            m_tuser,   // kind
    output logic                  m_tlast,   // last

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [TIME_WIDTH-1:0] cfg_data
);

    import irpwd_pkg::*;

    logic [TIME_WIDTH-1:0] margin_len;
    logic [TIME_WIDTH-1:0] sync_len;
    logic [TIME_WIDTH-1:0] pause_len;
    logic [TIME_WIDTH-1:0] bit_min_len;
    logic [TIME_WIDTH-1:0] bit_split_len;
    logic [TIME_WIDTH-1:0] bit_max_len;
    logic                  active_level;

    logic                  in_valid_reg;
    logic [TIME_WIDTH-1:0] in_len_reg;
    logic                  in_level_reg;
    logic                  in_tmo_reg;

    logic                  out_valid_reg;
    res_t                  out_reg;
    logic                  out_free;

    class_t                cls;
    logic                  res_valid;
    res_t                  res;
    seq_stat_t             stat;

    assign cfg_ready = 1'b1;

    irpwd_cfg_regs #(.TIME_WIDTH(TIME_WIDTH)) u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .wr_en         (cfg_valid && cfg_ready),
        .wr_index      (cfg_index),
        .wr_data       (cfg_data),
        .margin_len    (margin_len),
        .sync_len      (sync_len),
        .pause_len     (pause_len),
        .bit_min_len   (bit_min_len),
        .bit_split_len (bit_split_len),
        .bit_max_len   (bit_max_len),
        .active_level  (active_level)
    );

    // Input register: refills in the cycle its item is taken.
    assign s_tready = !in_valid_reg || stat.take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_len_reg   <= s_tdata[TIME_WIDTH-1:0];
            in_level_reg <= s_tdata[TIME_WIDTH];
            in_tmo_reg   <= s_tuser;
        end
    end

    irpwd_classify #(.TIME_WIDTH(TIME_WIDTH)) u_classify (
        .len           (in_len_reg),
        .margin_len    (margin_len),
        .sync_len      (sync_len),
        .pause_len     (pause_len),
        .bit_min_len   (bit_min_len),
        .bit_split_len (bit_split_len),
        .bit_max_len   (bit_max_len),
        .cls           (cls)
    );

    // The result register is free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || m_tready;

    irpwd_seq #(.MAX_BITS(MAX_BITS)) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (in_valid_reg),
        .in_level     (in_level_reg),
        .in_tmo       (in_tmo_reg),
        .cls          (cls),
        .active_level (active_level),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res          (res),
        .stat         (stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg.packet_word, out_reg.word_index,
                       out_reg.bit_total, out_reg.bit_value};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

    // Packet words go out back to back: a word that is not the last is
    // followed at once by the next one.
    a_words_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && (m_tuser == KIND_WORD) && !m_tlast)
        |=> (m_tvalid && (m_tuser == KIND_WORD)))
        else $error("packet word burst broken");

    // Sync, pause and bit results are always the only result of their item.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != KIND_WORD)) |-> m_tlast)
        else $error("single result without last");

    // While words are read from the bit store, no new item is taken in.
    a_hold_while_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.emitting && in_valid_reg) |-> !s_tready)
        else $error("input accepted during packet emission");

    // A packet word always follows a packet end, so the burst starts at word 0.
    a_first_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_WORD) && (m_tdata[11:10] != 2'd0))
        |-> $past(m_tvalid && (m_tuser == KIND_WORD)))
        else $error("packet word out of order");

endmodule
